@@ rtl/srbt_pkg.sv @@
// Shared types and constants for the sequence reorder buffer with timeout flush.
// Holds field widths, action and result codes, the sequencer state enum and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package srbt_pkg;

   // Fixed field widths
   localparam int SEQ_W    = 31;
   localparam int HANDLE_W = 16;
   localparam int TICK_W   = 16;

   // Hold time loaded after reset
   localparam logic [TICK_W-1:0] HOLD_TICKS_RESET = 16'd750;

   // Input action codes
   localparam logic ACTION_ITEM = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Result kind codes
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_DROP    = 1'b1;

   // Table sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DROP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_FLUSH_RD,
      ST_FLUSH_OUT
   } state_type;

   // One result item
   typedef struct packed {
      logic                kind;
      logic [SEQ_W-1:0]    out_seq;
      logic [HANDLE_W-1:0] out_payload;
      logic                last_of_run;
   } rsp_item_type;

endpackage

@@ rtl/sequence_reorder_buffer_timeout_core.sv @@
// Sequence reorder buffer with timeout flush core; depends on srbt_pkg and srbt_rsp_stage.
// An in-order item reaches the output register in the cycle after it is taken.
// A held item is compared entry by entry (read, then compare), the entries above its place
// are moved up (read, then write) and it is written, or dropped if the table is full.
// A flush reads and outputs each entry in order; the table takes one read or one write per step.
// Reset (synchronous, active high) clears the timer, hold flag, last number and fill count.
`timescale 1ns / 1ps

module sequence_reorder_buffer_timeout_core #(
   parameter int TABLE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [srbt_pkg::SEQ_W-1:0]    req_seq_number,
   input  logic [srbt_pkg::HANDLE_W-1:0] req_payload_handle,
   input  logic [srbt_pkg::TICK_W-1:0]   req_elapsed_ticks,
   // Result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [srbt_pkg::SEQ_W-1:0]    rsp_out_seq,
   output logic [srbt_pkg::HANDLE_W-1:0] rsp_out_payload,
   output logic                          rsp_last_of_run,
   // Hold time register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srbt_pkg::TICK_W-1:0]   csr_hold_ticks
);
   import srbt_pkg::*;

   localparam int IW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int EW     = SEQ_W + PAYLOAD_BITS;
   localparam int PW_MAX = (PAYLOAD_BITS > HANDLE_W) ? PAYLOAD_BITS : HANDLE_W;

   // Scalar state
   state_type           state_ff, state_in;
   logic [TICK_W-1:0]   hold_ticks_ff, hold_ticks_in;
   logic [SEQ_W-1:0]    last_ff, last_in;
   logic                holding_ff, holding_in;
   logic [TICK_W-1:0]   remain_ff, remain_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SEQ_W-1:0]    item_seq_ff, item_seq_in;
   logic [HANDLE_W-1:0] item_pay_ff, item_pay_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       pos_ff, pos_in;

   // Table memory, kept sorted by sequence number over its first count_ff entries
   logic [EW-1:0]       mem [TABLE_DEPTH];
   logic [EW-1:0]       rd_data_ff;
   logic                mem_re;
   logic [IW-1:0]       mem_ra;
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   logic [EW-1:0]       mem_wd;

   // Result path
   logic                out_free;
   logic                out_load;
   rsp_item_type        out_item;

   // Decoded views
   logic                req_take;
   logic                in_order;
   logic                needs_out;
   logic                table_full;
   logic                idx_is_top;
   logic [SEQ_W-1:0]    rd_seq;
   logic [PW_MAX-1:0]   rd_pay_ext;
   logic [PW_MAX-1:0]   item_pay_ext;

   assign rd_seq       = rd_data_ff[EW-1 -: SEQ_W];
   assign rd_pay_ext   = PW_MAX'(rd_data_ff[PAYLOAD_BITS-1:0]);
   assign item_pay_ext = PW_MAX'(item_pay_ff);
   assign table_full   = (count_ff == CW'(TABLE_DEPTH));
   assign idx_is_top   = (CW'(idx_ff) == count_ff - CW'(1));

   assign in_order  = (last_ff == '0) || (req_seq_number == last_ff + SEQ_W'(1));
   // Only an immediate delivery needs the output slot at accept time
   assign needs_out = (req_action == ACTION_ITEM) && (req_seq_number != '0)
                      && !holding_ff && in_order;
   assign req_stall = (state_ff != ST_IDLE) || (needs_out && !out_free);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACTION_TICK) begin
                  if (holding_ff && (req_elapsed_ticks >= remain_ff) && (count_ff != '0)) begin
                     state_in = ST_FLUSH_RD;
                  end
               end else if ((req_seq_number != '0) && (holding_ff || !in_order)) begin
                  state_in = (count_ff == '0) ? ST_INSERT : ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_seq == item_seq_ff) begin
               state_in = ST_IDLE;
            end else if (rd_seq > item_seq_ff) begin
               state_in = table_full ? ST_DROP : ST_SHIFT_RD;
            end else if (idx_is_top) begin
               state_in = table_full ? ST_DROP : ST_INSERT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DROP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = (idx_ff == pos_ff) ? ST_INSERT : ST_SHIFT_RD;
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (out_free) begin
               state_in = idx_is_top ? ST_IDLE : ST_FLUSH_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and result loads
   always_comb begin
      hold_ticks_in = hold_ticks_ff;
      last_in       = last_ff;
      holding_in    = holding_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      item_seq_in   = item_seq_ff;
      item_pay_in   = item_pay_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      mem_re        = 1'b0;
      mem_ra        = idx_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = rd_data_ff;
      out_load      = 1'b0;
      out_item      = '{kind: KIND_DELIVER, out_seq: item_seq_ff,
                        out_payload: item_pay_ff, last_of_run: 1'b1};

      if (csr_valid && csr_ready) begin
         hold_ticks_in = csr_hold_ticks;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_seq_in = req_seq_number;
               item_pay_in = req_payload_handle;
               idx_in      = '0;
               pos_in      = '0;
               if (req_action == ACTION_TICK) begin
                  if (holding_ff) begin
                     if (req_elapsed_ticks >= remain_ff) begin
                        remain_in  = '0;
                        holding_in = 1'b0;
                     end else begin
                        remain_in = remain_ff - req_elapsed_ticks;
                     end
                  end
               end else if (req_seq_number != '0) begin
                  if (!holding_ff && in_order) begin
                     // Immediate in-order delivery
                     last_in  = req_seq_number;
                     out_load = 1'b1;
                     out_item = '{kind: KIND_DELIVER, out_seq: req_seq_number,
                                  out_payload: req_payload_handle, last_of_run: 1'b1};
                  end else if (!holding_ff) begin
                     // Gap seen: start a hold
                     holding_in = 1'b1;
                     last_in    = '0;
                     remain_in  = hold_ticks_ff;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            mem_re = 1'b1;
         end
         ST_SCAN_CMP: begin
            if (rd_seq > item_seq_ff) begin
               // Insert point found; shift from the top down
               pos_in = idx_ff;
               idx_in = IW'(count_ff - CW'(1));
            end else if (idx_is_top) begin
               pos_in = IW'(count_ff);
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_DROP: begin
            if (out_free) begin
               out_load = 1'b1;
               out_item.kind = KIND_DROP;
            end
         end
         ST_SHIFT_RD: begin
            mem_re = 1'b1;
         end
         ST_SHIFT_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff + IW'(1);
            mem_wd = rd_data_ff;
            if (idx_ff != pos_ff) begin
               idx_in = idx_ff - IW'(1);
            end
         end
         ST_INSERT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = {item_seq_ff, item_pay_ext[PAYLOAD_BITS-1:0]};
            count_in = count_ff + CW'(1);
         end
         ST_FLUSH_RD: begin
            mem_re = 1'b1;
         end
         ST_FLUSH_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_item = '{kind: KIND_DELIVER, out_seq: rd_seq,
                            out_payload: rd_pay_ext[HANDLE_W-1:0], last_of_run: idx_is_top};
               if (idx_is_top) begin
                  last_in  = rd_seq;
                  count_in = '0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_ticks_ff <= HOLD_TICKS_RESET;
         last_ff       <= '0;
         holding_ff    <= 1'b0;
         remain_ff     <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         hold_ticks_ff <= hold_ticks_in;
         last_ff       <= last_in;
         holding_ff    <= holding_in;
         remain_ff     <= remain_in;
         count_ff      <= count_in;
      end
   end

   // Working registers of the item in progress
   always_ff @(posedge clock) begin
      item_seq_ff <= item_seq_in;
      item_pay_ff <= item_pay_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
   end

   // Table memory: reads and writes fall in different sequencer steps, so they never overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   srbt_rsp_stage u_rsp_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .item            (out_item),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_payload (rsp_out_payload),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ rtl/srbt_rsp_stage.sv @@
// Output register for result items, parting the sequencer from the result channel.
// Depends on srbt_pkg for the result struct and field widths.
`timescale 1ns / 1ps

module srbt_rsp_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  srbt_pkg::rsp_item_type        item,
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [srbt_pkg::SEQ_W-1:0]    rsp_out_seq,
   output logic [srbt_pkg::HANDLE_W-1:0] rsp_out_payload,
   output logic                          rsp_last_of_run
);
   import srbt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   // Slot can take a new item when empty or being drained this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= item;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = data_ff.kind;
   assign rsp_out_seq     = data_ff.out_seq;
   assign rsp_out_payload = data_ff.out_payload;
   assign rsp_last_of_run = data_ff.last_of_run;

endmodule
